// ===== hw/rtl/psf_pkg.sv =====
package psf_pkg;

  localparam int CFG_W          = 32;
  localparam int CFG_IDX_W      = 1;
  localparam int TIMER_BITS_DEF = 32;

  localparam logic [CFG_W-1:0] DEFAULT_DELAY_MS = 32'd60000;

  localparam logic [CFG_IDX_W-1:0] CFG_SHUTDOWN_DELAY = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HMI_TIMEOUT    = 1'd1;

  typedef enum logic [1:0] {
    ST_ACTIVE  = 2'd0,
    ST_SHUTREQ = 2'd1,
    ST_SLEEP   = 2'd2,
    ST_HMI     = 2'd3
  } fsm_state_t;

  typedef enum logic [1:0] {
    WAKE_POWER_ON = 2'd0,
    WAKE_ALARM    = 2'd1,
    WAKE_USER     = 2'd2
  } wake_cause_t;

  typedef enum logic [1:0] {
    BTN_NONE = 2'd0,
    BTN_A    = 2'd1,
    BTN_B    = 2'd2
  } button_report_t;

  typedef struct packed {
    logic mode;
    logic shutdown_request;
    logic shutdown_abort;
    logic alarm_wakeup;
    logic user_wakeup;
    logic button_a;
    logic button_b;
  } in_item_t;

  typedef struct packed {
    fsm_state_t     fsm_state;
    wake_cause_t    wake_cause;
    logic           rail_on;
    logic           host_power_on;
    button_report_t button_report;
  } result_t;

  typedef struct packed {
    logic [CFG_W-1:0] shutdown_delay_ms;
    logic [CFG_W-1:0] hmi_timeout_ms;
  } cfg_t;

endpackage

// ===== hw/rtl/psf_cfg_regs.sv =====
module psf_cfg_regs
  import psf_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_addr,
  input  logic [CFG_W-1:0]     cfg_wdata,
  output cfg_t                 cfg
);

  logic [CFG_W-1:0] shutdown_delay_r, shutdown_delay_nxt;
  logic [CFG_W-1:0] hmi_timeout_r, hmi_timeout_nxt;

  always_comb begin
    shutdown_delay_nxt = shutdown_delay_r;
    hmi_timeout_nxt    = hmi_timeout_r;
    if (cfg_we) begin
      case (cfg_addr)
        CFG_SHUTDOWN_DELAY: shutdown_delay_nxt = cfg_wdata;
        CFG_HMI_TIMEOUT:    hmi_timeout_nxt    = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shutdown_delay_r <= DEFAULT_DELAY_MS;
      hmi_timeout_r    <= DEFAULT_DELAY_MS;
    end else begin
      shutdown_delay_r <= shutdown_delay_nxt;
      hmi_timeout_r    <= hmi_timeout_nxt;
    end
  end

  assign cfg.shutdown_delay_ms = shutdown_delay_r;
  assign cfg.hmi_timeout_ms    = hmi_timeout_r;

endmodule

// ===== hw/rtl/psf_in_stage.sv =====
module psf_in_stage
  import psf_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t in_item,
  output logic     item_valid,
  output in_item_t item,
  input  logic     item_take
);

  logic     valid_r, valid_nxt;
  in_item_t item_r;
  logic     in_xfer;

  assign in_stall = valid_r && !item_take;
  assign in_xfer  = in_valid && !in_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (in_xfer) begin
      valid_nxt = 1'b1;
    end else if (item_take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      item_r <= in_item;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

// ===== hw/rtl/psf_ctrl.sv =====
module psf_ctrl
  import psf_pkg::*;
#(
  parameter int TIMER_BITS = TIMER_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  cfg_t     cfg,
  input  logic     item_valid,
  input  in_item_t item,
  output logic     item_take,
  output logic     out_valid,
  input  logic     out_stall,
  output result_t  result
);

  localparam logic [CFG_W-1:0] TMAX = CFG_W'((64'd1 << TIMER_BITS) - 64'd1);

  fsm_state_t            state_r, state_nxt;
  wake_cause_t           wake_r, wake_nxt;
  logic [TIMER_BITS-1:0] elapsed_r, elapsed_nxt;
  logic                  rail_r, rail_nxt;
  logic                  host_r, host_nxt;
  logic                  out_valid_r, out_valid_nxt;
  result_t               result_r;
  button_report_t        report;
  logic [CFG_W-1:0]      limit_raw, limit;
  logic [TIMER_BITS-1:0] elapsed_inc;
  logic                  any_flag;

  assign item_take = item_valid && (!out_valid_r || !out_stall);

  assign any_flag = item.shutdown_request || item.shutdown_abort || item.alarm_wakeup ||
                    item.user_wakeup || item.button_a || item.button_b;

  assign limit_raw   = (state_r == ST_SHUTREQ) ? cfg.shutdown_delay_ms : cfg.hmi_timeout_ms;
  assign limit       = (limit_raw > TMAX) ? TMAX : limit_raw;
  assign elapsed_inc = (CFG_W'(elapsed_r) == TMAX) ? elapsed_r
                                                   : elapsed_r + TIMER_BITS'(1);

  always_comb begin
    state_nxt   = state_r;
    wake_nxt    = wake_r;
    elapsed_nxt = elapsed_r;
    rail_nxt    = rail_r;
    host_nxt    = host_r;
    report      = BTN_NONE;

    if (!item.mode) begin
      if (state_r == ST_SHUTREQ || state_r == ST_HMI) begin
        elapsed_nxt = elapsed_inc;
        if (CFG_W'(elapsed_inc) >= limit) begin
          state_nxt = ST_SLEEP;
        end
      end
    end else if (any_flag) begin
      case (state_r)
        ST_ACTIVE: begin
          if (item.shutdown_request) begin
            state_nxt = ST_SHUTREQ;
          end
        end
        ST_SHUTREQ: begin
          state_nxt = (item.shutdown_abort || item.alarm_wakeup) ? ST_ACTIVE : ST_SLEEP;
        end
        ST_SLEEP: begin
          if (item.alarm_wakeup) begin
            wake_nxt  = WAKE_ALARM;
            state_nxt = ST_ACTIVE;
          end else if (item.user_wakeup) begin
            wake_nxt  = WAKE_USER;
            state_nxt = ST_ACTIVE;
          end else if (item.button_a || item.button_b) begin
            state_nxt = ST_HMI;
          end
        end
        ST_HMI: begin
          if (item.alarm_wakeup) begin
            wake_nxt  = WAKE_ALARM;
            state_nxt = ST_ACTIVE;
          end else if (item.button_a) begin
            report    = BTN_A;
            state_nxt = ST_SLEEP;
          end else if (item.button_b) begin
            report    = BTN_B;
            state_nxt = ST_SLEEP;
          end else if (item.user_wakeup) begin
            wake_nxt  = WAKE_USER;
            state_nxt = ST_ACTIVE;
          end else begin
            state_nxt = ST_SLEEP;
          end
        end
        default: state_nxt = state_r;
      endcase
    end

    // entry/exit actions
    if (state_nxt != state_r) begin
      elapsed_nxt = '0;
      if (state_r == ST_SLEEP) begin
        rail_nxt = 1'b1;
      end
      if (state_nxt == ST_SLEEP) begin
        rail_nxt = 1'b0;
        host_nxt = 1'b0;
      end else if (state_nxt == ST_ACTIVE) begin
        host_nxt = 1'b1;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (item_take) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_ACTIVE;
      wake_r      <= WAKE_POWER_ON;
      elapsed_r   <= '0;
      rail_r      <= 1'b1;
      host_r      <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (item_take) begin
        state_r   <= state_nxt;
        wake_r    <= wake_nxt;
        elapsed_r <= elapsed_nxt;
        rail_r    <= rail_nxt;
        host_r    <= host_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_take) begin
      result_r.fsm_state     <= state_nxt;
      result_r.wake_cause    <= wake_nxt;
      result_r.rail_on       <= rail_nxt;
      result_r.host_power_on <= host_nxt;
      result_r.button_report <= report;
    end
  end

  assign out_valid = out_valid_r;
  assign result    = result_r;

endmodule

// ===== hw/rtl/power_sequencing_fsm.sv =====
// Power-sequencing controller.
// Input channel (in_valid / in_stall): one item per transfer. in_mode = 0 is a
// 1 ms tick, in_mode = 1 an event word of six flags; an empty event word and
// ticks outside the timed states leave the state alone.
// Result channel (out_valid / out_stall): exactly one result per input item,
// in order: state after the item, wake cause, rail and host power enables, and
// the button reported from hmi.
// Config port: cfg_we with cfg_addr 0 = shutdown delay, 1 = hmi timeout (ms
// ticks); write only while the block is idle.
// Path: an input transfer is registered in the input register, then the state
// update writes the result register, where out_valid rises. Throughput: one
// item per cycle while out_stall is low, set by the combinational next-state
// and timer compare.
// A stalled result holds; one more item waits in the input register, after
// which in_stall rises until the result is taken.
// Reset: state active, wake cause power on, rail and host powered, timer
// cleared, both delays 60000, pipeline empty.
module power_sequencing_fsm
  import psf_pkg::*;
#(
  parameter int TIMER_BITS = TIMER_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_mode,
  input  logic                 in_ev_shutdown_request,
  input  logic                 in_ev_shutdown_abort,
  input  logic                 in_ev_alarm_wakeup,
  input  logic                 in_ev_user_wakeup,
  input  logic                 in_ev_button_a,
  input  logic                 in_ev_button_b,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [1:0]           out_fsm_state_out,
  output logic [1:0]           out_wake_cause,
  output logic                 out_rail_on,
  output logic                 out_host_power_on,
  output logic [1:0]           out_button_report,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_addr,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  cfg_t     cfg;
  in_item_t in_item;
  in_item_t item;
  logic     item_valid;
  logic     item_take;
  result_t  result;

  assign in_item.mode             = in_mode;
  assign in_item.shutdown_request = in_ev_shutdown_request;
  assign in_item.shutdown_abort   = in_ev_shutdown_abort;
  assign in_item.alarm_wakeup     = in_ev_alarm_wakeup;
  assign in_item.user_wakeup      = in_ev_user_wakeup;
  assign in_item.button_a         = in_ev_button_a;
  assign in_item.button_b         = in_ev_button_b;

  psf_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  psf_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take)
  );

  psf_ctrl #(
    .TIMER_BITS (TIMER_BITS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .result     (result)
  );

  assign out_fsm_state_out = result.fsm_state;
  assign out_wake_cause    = result.wake_cause;
  assign out_rail_on       = result.rail_on;
  assign out_host_power_on = result.host_power_on;
  assign out_button_report = result.button_report;

endmodule
